FILE: rtl/core/iasmd_pkg.sv
package iasmd_pkg;

  localparam int DEFAULT_DATA_WIDTH = 32;

  // per-item control flags that travel down the chain alongside the data
  typedef struct packed {
    logic valid;
    logic neg_q;
    logic dz;
  } iasmd_ctrl_t;

endpackage

FILE: rtl/core/iasmd_prep.sv
module iasmd_prep #(
  parameter int DATA_WIDTH = iasmd_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  input  logic                          valid_i,
  input  logic [DATA_WIDTH-1:0]         a_i,
  input  logic [DATA_WIDTH-1:0]         b_i,
  output iasmd_pkg::iasmd_ctrl_t        ctrl_o,
  output logic [DATA_WIDTH-1:0]         a_o,
  output logic [DATA_WIDTH-1:0]         b_o,
  output logic [DATA_WIDTH-1:0]         ma_o,
  output logic [DATA_WIDTH-1:0]         mb_o,
  output logic [DATA_WIDTH-1:0]         sum_o,
  output logic [DATA_WIDTH-1:0]         diff_o
);
  import iasmd_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  iasmd_ctrl_t           ctrl_r, ctrl_nxt;
  logic [DATA_WIDTH-1:0] a_r, b_r, ma_r, mb_r, sum_r, diff_r;
  logic [DATA_WIDTH-1:0] ma_nxt, mb_nxt;

  always_comb begin
    // magnitude of the most negative value stays 2^(W-1) as unsigned
    ma_nxt         = a_i[DATA_WIDTH-1] ? (~a_i + ONE) : a_i;
    mb_nxt         = b_i[DATA_WIDTH-1] ? (~b_i + ONE) : b_i;
    ctrl_nxt.valid = valid_i;
    ctrl_nxt.neg_q = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
    ctrl_nxt.dz    = (b_i == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (enable) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      a_r    <= a_i;
      b_r    <= b_i;
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      sum_r  <= a_i + b_i;
      diff_r <= a_i - b_i;
    end
  end

  assign ctrl_o = ctrl_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign ma_o   = ma_r;
  assign mb_o   = mb_r;
  assign sum_o  = sum_r;
  assign diff_o = diff_r;

endmodule

FILE: rtl/core/iasmd_cell.sv
module iasmd_cell #(
  parameter int DATA_WIDTH = iasmd_pkg::DEFAULT_DATA_WIDTH,
  parameter int BIT        = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  input  iasmd_pkg::iasmd_ctrl_t        ctrl_i,
  input  logic [DATA_WIDTH-1:0]         x_i,
  input  logic [DATA_WIDTH-1:0]         y_i,
  input  logic [DATA_WIDTH-1:0]         q_i,
  input  logic [DATA_WIDTH-1:0]         a_i,
  input  logic [DATA_WIDTH-1:0]         b_i,
  input  logic [DATA_WIDTH-1:0]         acc_i,
  input  logic [DATA_WIDTH-1:0]         sum_i,
  input  logic [DATA_WIDTH-1:0]         diff_i,
  output iasmd_pkg::iasmd_ctrl_t        ctrl_o,
  output logic [DATA_WIDTH-1:0]         x_o,
  output logic [DATA_WIDTH-1:0]         y_o,
  output logic [DATA_WIDTH-1:0]         q_o,
  output logic [DATA_WIDTH-1:0]         a_o,
  output logic [DATA_WIDTH-1:0]         b_o,
  output logic [DATA_WIDTH-1:0]         acc_o,
  output logic [DATA_WIDTH-1:0]         sum_o,
  output logic [DATA_WIDTH-1:0]         diff_o
);
  import iasmd_pkg::*;

  iasmd_ctrl_t           ctrl_r;
  logic [DATA_WIDTH-1:0] x_r, y_r, q_r, a_r, b_r, acc_r, sum_r, diff_r;
  logic [DATA_WIDTH-1:0] x_nxt, q_nxt, acc_nxt;
  logic [DATA_WIDTH-1:0] x_shr;
  logic [DATA_WIDTH:0]   trial;
  logic                  fit;

  always_comb begin
    // restoring step: does y fit into the remainder at this bit position
    x_shr = x_i >> BIT;
    trial = {1'b0, x_shr} - {1'b0, y_i};
    fit   = !trial[DATA_WIDTH];
    x_nxt = fit ? (x_i - (y_i << BIT)) : x_i;
    q_nxt = q_i;
    q_nxt[BIT] = fit;
    // shift-add step of the multiplier, low bits only
    acc_nxt = b_i[BIT] ? (acc_i + (a_i << BIT)) : acc_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (enable) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      x_r    <= x_nxt;
      y_r    <= y_i;
      q_r    <= q_nxt;
      a_r    <= a_i;
      b_r    <= b_i;
      acc_r  <= acc_nxt;
      sum_r  <= sum_i;
      diff_r <= diff_i;
    end
  end

  assign ctrl_o = ctrl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign q_o    = q_r;
  assign a_o    = a_r;
  assign b_o    = b_r;
  assign acc_o  = acc_r;
  assign sum_o  = sum_r;
  assign diff_o = diff_r;

endmodule

FILE: rtl/core/int_add_sub_mul_div_unit.sv
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------------
// input   | in_valid / in_ready  | in_operand_a, in_operand_b
// output  | out_valid/out_ready  | out_sum_out, out_difference_out, out_product_out,
//         |                      | out_quotient_out, out_divide_by_zero
//
// Throughput: one item per cycle while no result is held at the output by out_ready low. The
// pipeline is the operand prep stage, then a chain of DATA_WIDTH cells, each doing one divide
// step and one multiply step per operand bit, then the output register.
// Reset (rst_n low, synchronous) empties the pipeline; payload registers are not reset.
// A result waiting at the output with out_ready low freezes the whole chain.
module int_add_sub_mul_div_unit #(
  parameter int DATA_WIDTH = iasmd_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [DATA_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_sum_out,
  output logic signed [DATA_WIDTH-1:0] out_difference_out,
  output logic signed [DATA_WIDTH-1:0] out_product_out,
  output logic signed [DATA_WIDTH-1:0] out_quotient_out,
  output logic                         out_divide_by_zero
);
  import iasmd_pkg::*;

  localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  logic enable;

  iasmd_ctrl_t           st_ctrl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_x    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_y    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_q    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_a    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_b    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_acc  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_sum  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] st_diff [0:DATA_WIDTH];

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] sum_r, diff_r, prod_r, quot_r, quot_nxt;
  logic                  dz_r;
  iasmd_ctrl_t           last_ctrl;
  logic [DATA_WIDTH-1:0] last_q;

  // whole chain advances unless a finished item is stuck at the output
  assign enable   = !out_valid_r || out_ready;
  assign in_ready = enable;

  iasmd_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable  (enable),
    .valid_i (in_valid),
    .a_i     (in_operand_a),
    .b_i     (in_operand_b),
    .ctrl_o  (st_ctrl[0]),
    .a_o     (st_a[0]),
    .b_o     (st_b[0]),
    .ma_o    (st_x[0]),
    .mb_o    (st_y[0]),
    .sum_o   (st_sum[0]),
    .diff_o  (st_diff[0])
  );

  assign st_q[0]   = '0;
  assign st_acc[0] = '0;

  // cell k handles bit DATA_WIDTH-1-k, most significant quotient bit first
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    iasmd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .BIT        (DATA_WIDTH - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .enable (enable),
      .ctrl_i (st_ctrl[k]),
      .x_i    (st_x[k]),
      .y_i    (st_y[k]),
      .q_i    (st_q[k]),
      .a_i    (st_a[k]),
      .b_i    (st_b[k]),
      .acc_i  (st_acc[k]),
      .sum_i  (st_sum[k]),
      .diff_i (st_diff[k]),
      .ctrl_o (st_ctrl[k+1]),
      .x_o    (st_x[k+1]),
      .y_o    (st_y[k+1]),
      .q_o    (st_q[k+1]),
      .a_o    (st_a[k+1]),
      .b_o    (st_b[k+1]),
      .acc_o  (st_acc[k+1]),
      .sum_o  (st_sum[k+1]),
      .diff_o (st_diff[k+1])
    );
  end

  assign last_ctrl = st_ctrl[DATA_WIDTH];
  assign last_q    = st_q[DATA_WIDTH];

  always_comb begin
    // zero divisor leaves an all-ones magnitude quotient; force it to zero
    if (last_ctrl.dz) begin
      quot_nxt = '0;
    end else if (last_ctrl.neg_q) begin
      quot_nxt = ~last_q + ONE;
    end else begin
      quot_nxt = last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (enable) begin
      out_valid_r <= last_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      sum_r  <= st_sum[DATA_WIDTH];
      diff_r <= st_diff[DATA_WIDTH];
      prod_r <= st_acc[DATA_WIDTH];
      quot_r <= quot_nxt;
      dz_r   <= last_ctrl.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sum_out        = sum_r;
  assign out_difference_out = diff_r;
  assign out_product_out    = prod_r;
  assign out_quotient_out   = quot_r;
  assign out_divide_by_zero = dz_r;

  // zero divisor: quotient is zero, product is zero and sum equals difference
  a_dz_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> (quot_r == '0) && (prod_r == '0) && (sum_r == diff_r))
    else $error("zero divisor result inconsistent");

  // a stalled output freezes the chain's occupancy
  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !enable |=> $stable(last_ctrl.valid) && $stable(st_ctrl[0].valid) && out_valid_r)
    else $error("chain moved while output stalled");

  // item entering prep stage corresponds to an accepted input
  a_prep_fill: assert property (@(posedge clk) disable iff (!rst_n)
    enable |=> (st_ctrl[0].valid == $past(in_valid)))
    else $error("prep stage valid does not follow accepted input");

  // nonzero divisor: when sum equals difference, a quotient that is neither zero nor wrapped is non-negative
  a_quot_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !dz_r && (quot_r != '0) && (quot_r != (ONE << (DATA_WIDTH - 1)))
      |-> (quot_r[DATA_WIDTH-1] == (sum_r != diff_r ? quot_r[DATA_WIDTH-1] : 1'b0)))
    else $error("quotient sign error");

endmodule

FILE: verif/tb_int_add_sub_mul_div_unit.sv
module tb_int_add_sub_mul_div_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW          = iasmd_pkg::DEFAULT_DATA_WIDTH;
  localparam int LATENCY     = DW + 2;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINUS_ONE = {DW{1'b1}};

  typedef struct packed {
    logic [DW-1:0] sum;
    logic [DW-1:0] diff;
    logic [DW-1:0] prod;
    logic [DW-1:0] quot;
    logic          dz;
  } arith_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_operand_a = '0;
  logic [DW-1:0] in_operand_b = '0;

  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] out_sum_out;
  logic [DW-1:0] out_difference_out;
  logic [DW-1:0] out_product_out;
  logic [DW-1:0] out_quotient_out;
  logic          out_divide_by_zero;

  arith_result_t expected_results[$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycle_count = 0;

  int_add_sub_mul_div_unit #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sum_out       (out_sum_out),
    .out_difference_out(out_difference_out),
    .out_product_out   (out_product_out),
    .out_quotient_out  (out_quotient_out),
    .out_divide_by_zero(out_divide_by_zero)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sum, difference, product, and a truncating quotient built from an
  // unsigned restoring divide of the magnitudes
  function automatic arith_result_t predict_arith(logic [DW-1:0] a, logic [DW-1:0] b);
    arith_result_t r;
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW-1:0] q;
    logic [DW:0]   rem;
    r.sum  = a + b;
    r.diff = a - b;
    r.prod = a * b;
    r.quot = '0;
    r.dz   = (b == '0);
    if (!r.dz) begin
      mag_a = a[DW-1] ? -a : a;
      mag_b = b[DW-1] ? -b : b;
      q     = '0;
      rem   = '0;
      for (int i = DW - 1; i >= 0; i--) begin
        rem = {rem[DW-1:0], mag_a[i]};
        if (rem >= {1'b0, mag_b}) begin
          rem  = rem - {1'b0, mag_b};
          q[i] = 1'b1;
        end
      end
      r.quot = (a[DW-1] ^ b[DW-1]) ? -q : q;
    end
    return r;
  endfunction

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_operands(logic [DW-1:0] a, logic [DW-1:0] b);
    logic accepted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    do begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end while (!accepted);
    expected_results.push_back(predict_arith(a, b));
  endtask

  // called just after a rising edge; stops offering items and waits for the results
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 1;
          2: v = MINUS_ONE;
          3: v = MOST_NEG;
          default: v = MOST_POS;
        endcase
      end
      1: v = $urandom_range(32) - 16;
      2: begin
        v = 1 << $urandom_range(DW - 1);
        if ($urandom_range(1)) v = -v;
      end
      3: v = $urandom_range(65535);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random_operands(int count);
    for (int n = 0; n < count; n++) send_operands(pick_operand(), pick_operand());
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(string field, logic [DW-1:0] exp_val, logic [DW-1:0] act_val);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, exp_val, act_val);
  endtask

  // handshake signals settle by the falling edge; the item moves at the next rising edge
  always @(negedge clk) begin
    arith_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item, expected none, actual sum %h", $realtime, out_sum_out);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_sum_out !== exp_r.sum) report_mismatch("sum", exp_r.sum, out_sum_out);
        if (out_difference_out !== exp_r.diff)
          report_mismatch("difference", exp_r.diff, out_difference_out);
        if (out_product_out !== exp_r.prod)
          report_mismatch("product", exp_r.prod, out_product_out);
        if (out_quotient_out !== exp_r.quot)
          report_mismatch("quotient", exp_r.quot, out_quotient_out);
        if (out_divide_by_zero !== exp_r.dz)
          report_mismatch("divide_by_zero", {{(DW-1){1'b0}}, exp_r.dz},
                          {{(DW-1){1'b0}}, out_divide_by_zero});
      end
    end
  end

  task automatic test_corner_operands();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_operands('0, '0);
    send_operands(32'sd5, '0);
    send_operands(MOST_NEG, '0);
    send_operands(MOST_NEG, MINUS_ONE);
    send_operands(MOST_NEG, 1);
    send_operands(MOST_POS, MINUS_ONE);
    send_operands(MOST_NEG, MOST_NEG);
    send_operands(MOST_POS, MOST_POS);
    send_operands(MOST_POS, MOST_NEG);
    send_operands(1, MOST_NEG);
    send_operands(MOST_NEG, 2);
    send_operands(MOST_POS, 2);
    send_operands(-32'sd7, 32'sd2);
    send_operands(32'sd7, -32'sd2);
    send_operands(-32'sd7, -32'sd2);
    send_operands(32'sd7, 32'sd2);
    send_operands(MINUS_ONE, MINUS_ONE);
    send_operands('0, -32'sd5);
    send_operands(32'sd100, 32'sd7);
    send_operands(32'sd12345678, -32'sd3);
    send_operands(MINUS_ONE, MOST_POS);
    send_operands(32'hFFFF_FFFF, 32'h0001_0000);
    wait_for_drain();
  endtask

  task automatic test_random_no_idle();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_random_operands(110);
  endtask

  task automatic test_random_sender_idle();
    sender_idle_pct = 66;
    recv_stall_pct  = 0;
    send_random_operands(200);
  endtask

  task automatic test_random_receiver_stall();
    sender_idle_pct = 0;
    recv_stall_pct  = 66;
    send_random_operands(200);
  endtask

  task automatic test_random_both_idle();
    sender_idle_pct = 33;
    recv_stall_pct  = 33;
    send_random_operands(200);
  endtask

  // long receiver hold-off while items keep coming, so the chain fills and stalls input
  task automatic test_full_pipeline_stall();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_asked++;
    send_random_operands(120);
    wait_for_drain();
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_operands();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_full_pipeline_stall();
    recv_stall_pct = 0;
    wait_for_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
